@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the list block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/alist_pkg.sv @@
// ----------------------------------------------------------------------------
// alist_pkg
// Types and codes for the fixed-capacity ordered list.
// ----------------------------------------------------------------------------
package alist_pkg;

   localparam int POS_W = 7;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_DEL_FRONT = 3'd2,
      OP_DEL_BACK  = 3'd3,
      OP_INS_AT    = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_SEARCH    = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      op_type             req_type;
      logic signed [31:0] value;
      logic [3:0]         position;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] entry_count;
      logic [2:0] match_index;
   } rsp_type;

   typedef struct packed {
      logic             ins_en;
      logic             del_en;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] count;
   } ctrl_type;

endpackage

@@ src/alist_cell.sv @@
// ----------------------------------------------------------------------------
// alist_cell
// One list slot: holds an entry, shifts with its neighbours, compares.
// ----------------------------------------------------------------------------
module alist_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  alist_pkg::ctrl_type       ctrl,
   input  logic signed [31:0]        value_new,
   input  logic signed [31:0]        lower_in,
   input  logic signed [31:0]        upper_in,
   output logic signed [31:0]        entry_out,
   output logic                      match
);
   import alist_pkg::*;

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic [POS_W-1:0]   idx;

   assign idx = POS_W'(INDEX);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (idx > ctrl.pos) begin
            entry_in = lower_in;
         end else if (idx == ctrl.pos) begin
            entry_in = value_new;
         end
      end else if (ctrl.del_en) begin
         if (idx >= ctrl.pos) begin
            entry_in = upper_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign match     = (idx < ctrl.count) && (entry_ff == value_new);

endmodule

@@ src/array_list_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// array_list_insert_delete_search
// Fixed-capacity ordered list of signed 32-bit values.
// ----------------------------------------------------------------------------
// Takes one request every clock cycle: busy stays low. All slots shift and
// compare in parallel in a row of cells, so each request finishes in the
// cycle it is taken and its result beat appears on rsp_item, marked by
// rsp_valid, for exactly one cycle starting at the next clock edge. The
// receiver cannot hold results off and must take every beat.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search #(
   parameter int CAPACITY = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  alist_pkg::req_type req_item,
   output logic               rsp_valid,
   output alist_pkg::rsp_type rsp_item
);
   import alist_pkg::*;

   `include "assert_macros.svh"

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   ctrl_type           ctrl;
   logic               accept;
   logic [POS_W-1:0]   cnt_x, pos_x;
   logic               full, empty;
   logic [CAPACITY-1:0] match_vec, first_vec;
   logic [IW-1:0]      first_idx;
   logic signed [31:0] entry_vec [CAPACITY];
   logic               rsp_full;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign cnt_x  = POS_W'(cnt_ff);
   assign pos_x  = POS_W'(req_item.position);
   assign full   = (cnt_x == POS_W'(CAPACITY));
   assign empty  = (cnt_ff == '0);

   assign first_vec = match_vec & (~match_vec + CAPACITY'(1));

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         first_idx = first_idx | (first_vec[i] ? IW'(i) : IW'(0));
      end
   end

   always_comb begin
      ctrl        = '0;
      ctrl.count  = cnt_x;
      rsp_in      = '0;
      rsp_in.status = ST_OK;
      unique case (req_item.req_type) inside
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            if (req_item.req_type == OP_INS_FRONT) begin
               ctrl.pos = '0;
            end else if (req_item.req_type == OP_INS_BACK) begin
               ctrl.pos = cnt_x;
            end else begin
               ctrl.pos = pos_x;
            end
            if (full) begin
               rsp_in.status = ST_FULL;
            end else if (ctrl.pos > cnt_x) begin
               rsp_in.status = ST_BADPOS;
            end else begin
               ctrl.ins_en = 1'b1;
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
            if (req_item.req_type == OP_DEL_FRONT) begin
               ctrl.pos = '0;
            end else if (req_item.req_type == OP_DEL_BACK) begin
               ctrl.pos = cnt_x - POS_W'(1);
            end else begin
               ctrl.pos = pos_x;
            end
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (ctrl.pos >= cnt_x) begin
               rsp_in.status = ST_BADPOS;
            end else begin
               ctrl.del_en = 1'b1;
            end
         end
         OP_SEARCH: begin
            if (|match_vec) begin
               rsp_in.match_index = 3'(first_idx);
            end else begin
               rsp_in.status = ST_NOTFOUND;
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         ctrl.ins_en = 1'b0;
         ctrl.del_en = 1'b0;
      end
      cnt_in = cnt_ff;
      if (ctrl.ins_en) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (ctrl.del_en) begin
         cnt_in = cnt_ff - CW'(1);
      end
      rsp_in.entry_count = 4'(cnt_in);
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] lower, upper;
      if (g == 0) begin : g_first
         assign lower = req_item.value;
      end else begin : g_lower
         assign lower = entry_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper = entry_vec[g];
      end else begin : g_upper
         assign upper = entry_vec[g+1];
      end
      alist_cell #(.INDEX(g)) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .value_new (req_item.value),
         .lower_in  (lower),
         .upper_in  (upper),
         .entry_out (entry_vec[g]),
         .match     (match_vec[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign rsp_full  = rsp_valid && (rsp_item.status == ST_FULL);

   `ASSERT_NEXT(a_beat_follows, clock, reset, accept, rsp_valid)
   `ASSERT_NEXT(a_no_stray_beat, clock, reset, !accept, !rsp_valid)
   `ASSERT_IMPLIES(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(CAPACITY))
   `ASSERT_IMPLIES(a_full_count, clock, reset, rsp_full, rsp_item.entry_count == 4'(CAPACITY))

endmodule

@@ sim/tb_array_list_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// tb_array_list_insert_delete_search
// Self-checking bench for the fixed-capacity ordered list.
// ----------------------------------------------------------------------------
// Requests are sent in bursts with random gaps between them. Each accepted
// request is run through a behavioural copy of the list held in the bench.
// That copy queues the status, count and match index that the request should
// return. Every result beat is checked against the oldest queued outcome.
// A short directed part covers the empty, full and bad-position cases, search
// on duplicates and the unused request code. A long random part then fills
// and drains the list repeatedly.
// ----------------------------------------------------------------------------
module tb_array_list_insert_delete_search;
   import alist_pkg::*;

   localparam int LIST_DEPTH   = 8;
   localparam int RANDOM_BEATS = 850;
   localparam int SHOWN_FAULTS = 10;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   logic signed [31:0] list_store [LIST_DEPTH];
   int                 list_fill;
   rsp_type            pending_outcomes [$];
   int                 fault_count;
   int                 rsp_seen;
   int                 burst_left;

   array_list_insert_delete_search #(
      .CAPACITY (LIST_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #200000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   function automatic status_type list_insert(input int pos, input logic signed [31:0] val);
      if (list_fill >= LIST_DEPTH) return ST_FULL;
      if (pos > list_fill) return ST_BADPOS;
      for (int i = list_fill; i > pos; i--) list_store[i] = list_store[i-1];
      list_store[pos] = val;
      list_fill++;
      return ST_OK;
   endfunction

   function automatic status_type list_remove(input int pos);
      if (list_fill == 0) return ST_EMPTY;
      if (pos >= list_fill) return ST_BADPOS;
      for (int i = pos; i + 1 < list_fill; i++) list_store[i] = list_store[i+1];
      list_fill--;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_list_op(input req_type beat);
      rsp_type outcome;
      outcome = '0;
      outcome.status = ST_OK;
      case (beat.req_type)
         OP_INS_FRONT: outcome.status = list_insert(0, beat.value);
         OP_INS_BACK:  outcome.status = list_insert(list_fill, beat.value);
         OP_DEL_FRONT: outcome.status = list_remove(0);
         OP_DEL_BACK:  outcome.status = (list_fill == 0) ? ST_EMPTY : list_remove(list_fill - 1);
         OP_INS_AT:    outcome.status = list_insert(int'(beat.position), beat.value);
         OP_DEL_AT:    outcome.status = list_remove(int'(beat.position));
         OP_SEARCH: begin
            outcome.status = ST_NOTFOUND;
            for (int i = 0; i < list_fill; i++) begin
               if (list_store[i] == beat.value) begin
                  outcome.status      = ST_OK;
                  outcome.match_index = i[2:0];
                  break;
               end
            end
         end
         default: ;
      endcase
      outcome.entry_count = list_fill[3:0];
      return outcome;
   endfunction

   // hold start until the beat is taken, then predict and idle between bursts
   task automatic push_request(input op_type op, input logic signed [31:0] val,
                               input logic [3:0] pos);
      req_type beat;
      int      gap;
      beat.req_type = op;
      beat.value    = val;
      beat.position = pos;
      start    <= 1'b1;
      req_item <= beat;
      do @(posedge clock); while (busy);
      pending_outcomes.push_back(predict_list_op(beat));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 6);
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) return $signed($urandom_range(0, 3)) - 2;
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_list();
      push_request(OP_DEL_FRONT, 32'sd0, 4'd0);
      push_request(OP_DEL_BACK, 32'sd0, 4'd0);
      push_request(OP_DEL_AT, 32'sd0, 4'd0);
      push_request(OP_SEARCH, 32'sd0, 4'd0);
      push_request(OP_INS_AT, 32'sd9, 4'd1);
      push_request(op_type'(3'd7), 32'sh7FFF_FFFF, 4'd15);
   endtask

   task automatic test_fill_to_capacity();
      push_request(OP_INS_BACK, 32'sh8000_0000, 4'd0);
      push_request(OP_INS_FRONT, 32'sh7FFF_FFFF, 4'd0);
      push_request(OP_INS_AT, -32'sd1, 4'd2);
      push_request(OP_INS_AT, 32'sd5, 4'd1);
      push_request(OP_INS_BACK, 32'sd5, 4'd0);
      push_request(OP_INS_FRONT, 32'sd0, 4'd0);
      push_request(OP_INS_AT, 32'sd1, 4'd15);
      push_request(OP_INS_BACK, 32'sh5555_5555, 4'd0);
      push_request(OP_INS_BACK, 32'shAAAA_AAAA, 4'd0);
      push_request(OP_INS_FRONT, 32'sd2, 4'd0);
      push_request(OP_INS_AT, 32'sd3, 4'd0);
      push_request(OP_INS_AT, 32'sd4, 4'd15);
   endtask

   task automatic test_search_and_delete();
      push_request(OP_SEARCH, 32'sd5, 4'd0);
      push_request(OP_SEARCH, 32'shAAAA_AAAA, 4'd0);
      push_request(OP_SEARCH, 32'sd123, 4'd0);
      push_request(OP_DEL_AT, 32'sd0, 4'd8);
      push_request(OP_DEL_AT, 32'sd0, 4'd7);
      push_request(OP_DEL_FRONT, 32'sd0, 4'd0);
      push_request(OP_DEL_BACK, 32'sd0, 4'd0);
   endtask

   task automatic test_random_traffic();
      int     sent;
      int     sel;
      bit     grow;
      op_type op;
      logic signed [31:0] val;
      logic [3:0]         pos;
      sent = 0;
      grow = 1'b1;
      while (sent < RANDOM_BEATS) begin
         if (list_fill == LIST_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
         if (list_fill == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
         if ($urandom_range(0, 39) == 0) grow = ~grow;
         sel = $urandom_range(0, 99);
         if (sel >= 97) begin
            op = op_type'(3'd7);
         end else if (sel >= 75) begin
            op = OP_SEARCH;
         end else if ((sel < 50) == grow) begin
            case ($urandom_range(0, 2))
               0: op = OP_INS_FRONT;
               1: op = OP_INS_BACK;
               default: op = OP_INS_AT;
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0: op = OP_DEL_FRONT;
               1: op = OP_DEL_BACK;
               default: op = OP_DEL_AT;
            endcase
         end
         if (op == OP_SEARCH && list_fill > 0 && $urandom_range(0, 2) != 0)
            val = list_store[$urandom_range(0, list_fill - 1)];
         else
            val = pick_value();
         if ($urandom_range(0, 99) < 15)
            pos = 4'($urandom_range(0, 15));
         else if (op == OP_INS_AT)
            pos = 4'($urandom_range(0, list_fill + 1));
         else
            pos = 4'($urandom_range(0, list_fill));
         push_request(op, val, pos);
         if (op != op_type'(3'd7)) sent++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (pending_outcomes.size() == 0) begin
            log_fault($sformatf("result beat %0d arrived with nothing expected", rsp_seen));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_item.status !== want.status)
               log_fault($sformatf("beat %0d status: expected %0d, got %0d",
                                   rsp_seen, want.status, rsp_item.status));
            if (rsp_item.entry_count !== want.entry_count)
               log_fault($sformatf("beat %0d entry_count: expected %0d, got %0d",
                                   rsp_seen, want.entry_count, rsp_item.entry_count));
            if (rsp_item.match_index !== want.match_index)
               log_fault($sformatf("beat %0d match_index: expected %0d, got %0d",
                                   rsp_seen, want.match_index, rsp_item.match_index));
         end
      end
   end

   initial begin
      int spins;
      fault_count = 0;
      rsp_seen    = 0;
      list_fill   = 0;
      burst_left  = $urandom_range(0, 6);
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_fill_to_capacity();
      test_search_and_delete();
      test_random_traffic();

      start <= 1'b0;
      spins = 0;
      while (pending_outcomes.size() != 0 && spins < 1000) begin
         @(posedge clock);
         spins++;
      end
      repeat (4) @(posedge clock);
      if (pending_outcomes.size() != 0)
         log_fault($sformatf("%0d expected results never arrived",
                             pending_outcomes.size()));

      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/alist_pkg.sv
src/alist_cell.sv
src/array_list_insert_delete_search.sv
sim/tb_array_list_insert_delete_search.sv
